### rtl/dost_pkg.sv
// ----------------------------------------------------------------------------
// Draw-order sort table package
// Types, codes and sizes shared by the sort table modules.
// ----------------------------------------------------------------------------
package dost_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    FUNC_ALLOC = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_READ  = 3'd2,
    FUNC_PASS  = 3'd3,
    FUNC_FULL  = 3'd4,
    FUNC_CLEAR = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SCAN_RD,
    S_SCAN_CK,
    S_SW_LOAD,
    S_SW_FIRST,
    S_SW_STEP,
    S_SW_LAST,
    S_TRIM_RD,
    S_TRIM_CK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [7:0]         layer;
    logic signed [15:0] y;
    logic [15:0]        tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         slot_index;
    logic               entry_valid;
    logic [7:0]         entry_layer;
    logic signed [15:0] entry_y;
    logic [15:0]        entry_tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         result_index;
    logic [6:0]         used_count;
    logic               read_valid;
    logic [7:0]         read_layer;
    logic signed [15:0] read_y;
    logic [15:0]        read_tag;
  } rsp_t;

endpackage

### rtl/dost_ram.sv
// ----------------------------------------------------------------------------
// Sort table RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dost_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 41
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/dost_cmp.sv
// ----------------------------------------------------------------------------
// Sort table key compare
// High when entry a belongs after entry b: valid first, then layer, then y.
// ----------------------------------------------------------------------------
module dost_cmp
  import dost_pkg::*;
(
  input  entry_t a_i,
  input  entry_t b_i,
  output logic   after_o
);

  always_comb begin
    if (!a_i.valid) begin
      after_o = b_i.valid;
    end else if (!b_i.valid) begin
      after_o = 1'b0;
    end else if (a_i.layer != b_i.layer) begin
      after_o = (a_i.layer > b_i.layer);
    end else begin
      after_o = ($signed(a_i.y) > $signed(b_i.y));
    end
  end

endmodule

### rtl/draw_order_sort_table.sv
// ----------------------------------------------------------------------------
// Draw-order sort table
// Keeps entries in a RAM; alloc, write, read, bubble pass, shaker sort, clear.
// ----------------------------------------------------------------------------
// One command at a time: busy is high from the accepting edge through the
// cycle of the result strobe, and the result sits on rsp_o for the single cycle
// done_o is high, with no way to hold it off. Write, clear and alloc with room
// go straight to the result; a read in range first reads the RAM slot. Alloc
// on a full table scans the RAM slot by slot for an invalid entry. A sort pass
// streams the used slots through one RAM read port and one key comparator at
// one pair a cycle, and a full shaker sort repeats that per sweep until a sweep
// swaps nothing or the range closes. Both sorts end by trimming invalid tail slots.
// The RAM has no clearing pass: every slot inside the used count has been
// written by alloc before it is ever read.
// ----------------------------------------------------------------------------
module draw_order_sort_table
  import dost_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output rsp_t rsp_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              back_q, back_d;
  logic              full_q, full_d;
  logic              fwd_q, fwd_d;
  logic              swp_q, swp_d;
  logic [IDX_W-1:0]  lo_q, lo_d;
  logic [IDX_W-1:0]  hi_q, hi_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  entry_t            carry_q, carry_d;
  rsp_t              res_q, res_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;

  entry_t            cmp_a, cmp_b;
  logic              cmp_after;

  logic              accept;
  logic              sw_bwd;
  logic [IDX_W-1:0]  sw_start, sw_end, cur_nxt;
  logic              step_last, more_sweeps;
  logic              slot_oob, has_room, scan_end;
  logic [IDX_W-1:0]  slot_idx, cnt_last;

  dost_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  dost_cmp u_cmp (
    .a_i    (cmp_a),
    .b_i    (cmp_b),
    .after_o(cmp_after)
  );

  assign accept      = start && (state_q == S_IDLE);
  assign sw_bwd      = full_q ? !fwd_q : back_q;
  assign sw_start    = sw_bwd ? hi_q : lo_q;
  assign sw_end      = sw_bwd ? lo_q : hi_q;
  assign cur_nxt     = sw_bwd ? cur_q - 1'b1 : cur_q + 1'b1;
  assign step_last   = (cur_nxt == sw_end);
  assign more_sweeps = swp_q && (({1'b0, lo_q} + 1'b1) < {1'b0, hi_q});
  assign slot_idx    = IDX_W'(cmd_i.slot_index);
  assign slot_oob    = (CNT_W'(cmd_i.slot_index) >= cnt_q);
  assign has_room    = (cnt_q < CNT_W'(TABLE_DEPTH));
  assign scan_end    = (cur_q == IDX_W'(TABLE_DEPTH - 1));
  assign cnt_last    = IDX_W'(cnt_q - 1'b1);

  // forward: carried entry against the next one; backward: next one against carry
  assign cmp_a = sw_bwd ? mem_rdata : carry_q;
  assign cmp_b = sw_bwd ? carry_q : mem_rdata;

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    rsp_o            = res_q;
    rsp_o.used_count = 7'(cnt_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.func)
            FUNC_ALLOC: state_d = has_room ? S_DONE : S_SCAN_RD;
            FUNC_READ:  state_d = slot_oob ? S_DONE : S_READ;
            FUNC_PASS,
            FUNC_FULL:  state_d = (cnt_q > CNT_W'(1)) ? S_SW_LOAD : S_TRIM_RD;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_READ:     state_d = S_DONE;
      S_SCAN_RD:  state_d = S_SCAN_CK;
      S_SCAN_CK: begin
        if (!mem_rdata.valid || scan_end) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SW_LOAD:  state_d = S_SW_FIRST;
      S_SW_FIRST: state_d = S_SW_STEP;
      S_SW_STEP:  state_d = step_last ? S_SW_LAST : S_SW_STEP;
      S_SW_LAST: begin
        if (full_q && more_sweeps) begin
          state_d = S_SW_LOAD;
        end else begin
          state_d = S_TRIM_RD;
        end
      end
      S_TRIM_RD:  state_d = (cnt_q == '0) ? S_DONE : S_TRIM_CK;
      S_TRIM_CK:  state_d = mem_rdata.valid ? S_DONE : S_TRIM_RD;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_d     = cnt_q;
    back_d    = back_q;
    full_d    = full_q;
    fwd_d     = fwd_q;
    swp_d     = swp_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    cur_d     = cur_q;
    carry_d   = carry_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        mem_raddr = slot_idx;
        if (accept) begin
          res_d  = '0;
          lo_d   = '0;
          hi_d   = cnt_last;
          cur_d  = '0;
          fwd_d  = 1'b1;
          full_d = (cmd_i.func == FUNC_FULL);
          case (cmd_i.func)
            FUNC_ALLOC: begin
              if (has_room) begin
                mem_we             = 1'b1;
                mem_waddr          = IDX_W'(cnt_q);
                res_d.result_index = 6'(cnt_q);
                cnt_d              = cnt_q + 1'b1;
              end
            end
            FUNC_WRITE: begin
              res_d.result_index = cmd_i.slot_index;
              if (slot_oob) begin
                res_d.status = ST_RANGE;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = slot_idx;
                mem_wdata.valid = cmd_i.entry_valid;
                mem_wdata.layer = cmd_i.entry_layer;
                mem_wdata.y     = cmd_i.entry_y;
                mem_wdata.tag   = cmd_i.entry_tag;
              end
            end
            FUNC_READ: begin
              res_d.result_index = cmd_i.slot_index;
              if (slot_oob) begin
                res_d.status = ST_RANGE;
              end
            end
            FUNC_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_d.read_valid = mem_rdata.valid;
        res_d.read_layer = mem_rdata.layer;
        res_d.read_y     = mem_rdata.y;
        res_d.read_tag   = mem_rdata.tag;
      end
      S_SCAN_RD: mem_raddr = cur_q;
      S_SCAN_CK: begin
        if (!mem_rdata.valid) begin
          mem_we             = 1'b1;
          res_d.result_index = 6'(cur_q);
        end else if (scan_end) begin
          res_d.status = ST_NO_FREE;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      S_SW_LOAD: begin
        mem_raddr = sw_start;
        swp_d     = 1'b0;
      end
      S_SW_FIRST: begin
        carry_d   = mem_rdata;
        cur_d     = sw_start;
        mem_raddr = sw_bwd ? sw_start - 1'b1 : sw_start + 1'b1;
      end
      S_SW_STEP: begin
        mem_we    = 1'b1;
        mem_wdata = cmp_after ? mem_rdata : carry_q;
        carry_d   = cmp_after ? carry_q : mem_rdata;
        swp_d     = swp_q | cmp_after;
        cur_d     = cur_nxt;
        mem_raddr = sw_bwd ? cur_nxt - 1'b1 : cur_nxt + 1'b1;
      end
      S_SW_LAST: begin
        mem_we    = 1'b1;
        mem_wdata = carry_q;
        if (full_q) begin
          fwd_d = !fwd_q;
          if (fwd_q) begin
            hi_d = hi_q - 1'b1;
          end else begin
            lo_d = lo_q + 1'b1;
          end
        end else begin
          back_d = !back_q;
        end
      end
      S_TRIM_RD: mem_raddr = cnt_last;
      S_TRIM_CK: begin
        if (!mem_rdata.valid) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      back_q  <= 1'b0;
      full_q  <= 1'b0;
      fwd_q   <= 1'b1;
      swp_q   <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      back_q  <= back_d;
      full_q  <= full_d;
      fwd_q   <= fwd_d;
      swp_q   <= swp_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    res_q   <= res_d;
  end

endmodule

### rtl/dost_chk.sv
// ----------------------------------------------------------------------------
// Draw-order sort table checker
// Port-level checks on command acceptance and result reporting.
// ----------------------------------------------------------------------------
module dost_chk
  import dost_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside busy window");

  a_done_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("block not free after result");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.used_count <= 7'(TABLE_DEPTH) && rsp_o.status != 2'd3)
    else $error("count or status out of range");

  a_no_free_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_NO_FREE |->
      rsp_o.used_count == 7'(TABLE_DEPTH) && rsp_o.result_index == '0)
    else $error("no-free status on a table that is not full");

endmodule

bind draw_order_sort_table dost_chk u_dost_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

### tb/draw_order_sort_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw-order sort table checker
// Keeps its own copy of the slot table, used count and sweep direction. It
// predicts one response per accepted item and compares each strobed response
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module draw_order_sort_table_checker
  import dost_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  cmd_t cmd_i,
  input  logic done_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  entry_t slots [TABLE_DEPTH];
  int     used;
  bit     backward;
  rsp_t   predicted_rsps [$];
  rsp_t   want;
  int     rsp_no;
  int     fails = 0;
  int     waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("response %0d: %s is %0h, predicted %0h",
                                rsp_no, name, got, exp_val));
    end
  endtask

  // -1: a goes first, 1: a goes after b, 0: same place
  function automatic int key_order(entry_t a, entry_t b);
    if (!a.valid) return b.valid ? 1 : 0;
    if (!b.valid) return -1;
    if (a.layer != b.layer) return (a.layer < b.layer) ? -1 : 1;
    if (a.y != b.y) return (a.y < b.y) ? -1 : 1;
    return 0;
  endfunction

  function automatic bit bubble_sweep(int lo, int hi, bit down);
    bit     moved;
    entry_t t;
    moved = 1'b0;
    if (!down) begin
      for (int i = lo; i < hi; i++) begin
        if (key_order(slots[i], slots[i + 1]) == 1) begin
          t = slots[i];
          slots[i] = slots[i + 1];
          slots[i + 1] = t;
          moved = 1'b1;
        end
      end
    end else begin
      for (int i = hi; i > lo; i--) begin
        if (key_order(slots[i], slots[i - 1]) == -1) begin
          t = slots[i];
          slots[i] = slots[i - 1];
          slots[i - 1] = t;
          moved = 1'b1;
        end
      end
    end
    return moved;
  endfunction

  function automatic void trim_tail();
    while (used > 0 && !slots[used - 1].valid) used--;
  endfunction

  function automatic rsp_t predict_rsp(cmd_t c);
    rsp_t   r;
    entry_t e;
    int     lo;
    int     hi;
    bit     fwd;
    r = '0;
    case (c.func)
      FUNC_ALLOC: begin
        if (used < TABLE_DEPTH) begin
          r.result_index = 6'(used);
          slots[used] = '0;
          used++;
        end else begin
          r.status = ST_NO_FREE;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!slots[i].valid) begin
              slots[i] = '0;
              r.result_index = 6'(i);
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      FUNC_WRITE: begin
        r.result_index = c.slot_index;
        if (c.slot_index >= used) begin
          r.status = ST_RANGE;
        end else begin
          slots[c.slot_index] = {c.entry_valid, c.entry_layer, c.entry_y, c.entry_tag};
        end
      end
      FUNC_READ: begin
        r.result_index = c.slot_index;
        if (c.slot_index >= used) begin
          r.status = ST_RANGE;
        end else begin
          e = slots[c.slot_index];
          r.read_valid = e.valid;
          r.read_layer = e.layer;
          r.read_y     = e.y;
          r.read_tag   = e.tag;
        end
      end
      FUNC_PASS: begin
        if (used > 1) begin
          void'(bubble_sweep(0, used - 1, backward));
          backward = !backward;
        end
        trim_tail();
      end
      FUNC_FULL: begin
        if (used > 1) begin
          lo  = 0;
          hi  = used - 1;
          fwd = 1'b1;
          while (lo < hi) begin
            if (!bubble_sweep(lo, hi, !fwd)) break;
            if (fwd) hi--;
            else lo++;
            fwd = !fwd;
          end
        end
        trim_tail();
      end
      FUNC_CLEAR: begin
        used = 0;
      end
      default: ;
    endcase
    r.used_count = 7'(used);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slots[i]) slots[i] = '0;
      used     = 0;
      backward = 1'b0;
      rsp_no   = 0;
      predicted_rsps.delete();
    end else begin
      if (done_i) begin
        if (predicted_rsps.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with no item outstanding", rsp_no));
        end else begin
          want = predicted_rsps.pop_front();
          check_field("status", 32'(rsp_i.status), 32'(want.status));
          check_field("result_index", 32'(rsp_i.result_index), 32'(want.result_index));
          check_field("used_count", 32'(rsp_i.used_count), 32'(want.used_count));
          check_field("read_valid", 32'(rsp_i.read_valid), 32'(want.read_valid));
          check_field("read_layer", 32'(rsp_i.read_layer), 32'(want.read_layer));
          check_field("read_y", 32'(rsp_i.read_y), 32'(want.read_y));
          check_field("read_tag", 32'(rsp_i.read_tag), 32'(want.read_tag));
        end
        rsp_no++;
      end
      if (start_i && !busy_i) predicted_rsps.push_back(predict_rsp(cmd_i));
    end
    waiting = predicted_rsps.size();
  end

endmodule

### tb/draw_order_sort_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw-order sort table testbench
// Directed items cover empty, boundary and tie cases, then four random phases
// each clear the table, fill it with alloc/write pairs (two run past capacity)
// and mix all commands, under changing sender idle rates.
// ----------------------------------------------------------------------------
module draw_order_sort_table_tb;
  import dost_pkg::*;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int         STALL_LIMIT   = 40000;
  localparam int         DRAIN_CYCLES  = 16;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  rsp_t        rsp;
  int          fail_count;
  int          pending;

  int unsigned sent_items   = 0;
  int unsigned got_items    = 0;
  rsp_t        last_rsp     = '0;
  int          idle_pct     = 0;
  int unsigned func_hits [8] = '{default: 0};
  int unsigned no_free_seen = 0;
  int unsigned range_seen   = 0;
  int unsigned peak_used    = 0;

  draw_order_sort_table i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd),
    .done_o (done),
    .rsp_o  (rsp)
  );

  draw_order_sort_table_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (done) begin
      got_items <= got_items + 1;
      last_rsp  <= rsp;
      if (rsp.status == ST_NO_FREE) no_free_seen <= no_free_seen + 1;
      if (rsp.status == ST_RANGE) range_seen <= range_seen + 1;
      if (32'(rsp.used_count) > peak_used) peak_used <= 32'(rsp.used_count);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("draw_order_sort_table verification failed");
    $finish;
  end

  function automatic cmd_t table_op(logic [2:0] f, int slot);
    cmd_t c;
    c = '0;
    c.func = f;
    c.slot_index = 6'(slot);
    return c;
  endfunction

  function automatic cmd_t slot_write(int slot, logic v, logic [7:0] layer,
                                      logic [15:0] y, logic [15:0] tag);
    cmd_t c;
    c = table_op(FUNC_WRITE, slot);
    c.entry_valid = v;
    c.entry_layer = layer;
    c.entry_y     = y;
    c.entry_tag   = tag;
    return c;
  endfunction

  // narrow key ranges half the time so ties and near-ties show up
  function automatic cmd_t random_write(int slot, int valid_pct);
    return slot_write(slot, $urandom_range(99) < valid_pct,
                      $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom),
                      $urandom_range(1) ? 16'($urandom_range(6) - 3) : 16'($urandom),
                      16'($urandom));
  endfunction

  function automatic int pick_slot();
    int cnt;
    cnt = int'(last_rsp.used_count);
    if (cnt == 0 || $urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(cnt - 1);
  endfunction

  task automatic send_cmd(input cmd_t c, input bit hold_off);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
    func_hits[c.func]++;
    if (hold_off) begin
      start <= 1'b0;
      while (got_items != sent_items) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (got_items != sent_items || pending != 0);
  endtask

  task automatic alloc_and_fill(int valid_pct);
    int slot;
    send_cmd(table_op(FUNC_ALLOC, 0), 1'b1);
    slot = (last_rsp.status == ST_OK) ? int'(last_rsp.result_index) : pick_slot();
    send_cmd(random_write(slot, valid_pct), 1'b0);
  endtask

  task automatic random_item(int valid_pct);
    cmd_t        c;
    logic [63:0] noise;
    int          pick;
    noise = {$urandom, $urandom};
    c     = noise[$bits(cmd_t)-1:0];
    pick  = $urandom_range(99);
    if (pick < 20) begin
      alloc_and_fill(valid_pct);
    end else begin
      if (pick < 35) begin
        c.func = FUNC_ALLOC;
      end else if (pick < 55) begin
        c = random_write(pick_slot(), valid_pct);
      end else if (pick < 75) begin
        c.func = FUNC_READ;
        c.slot_index = 6'(pick_slot());
      end else if (pick < 86) begin
        c.func = FUNC_PASS;
      end else if (pick < 92) begin
        c.func = FUNC_FULL;
      end else if (pick < 95) begin
        c.func = FUNC_CLEAR;
      end else begin
        c.func = $urandom_range(1) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
      end
      send_cmd(c, 1'b0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, boundaries, ties, both sweep directions, trim, stale data
    send_cmd(table_op(FUNC_READ, 0), 1'b0);
    send_cmd(slot_write(63, 1'b1, 8'hff, 16'h7fff, 16'hffff), 1'b0);
    send_cmd(table_op(FUNC_PASS, 0), 1'b0);
    send_cmd(table_op(FUNC_FULL, 0), 1'b0);
    repeat (4) send_cmd(table_op(FUNC_ALLOC, 0), 1'b0);
    send_cmd(slot_write(0, 1'b1, 8'hff, 16'h8000, 16'h0000), 1'b0);
    send_cmd(slot_write(1, 1'b1, 8'h00, 16'h7fff, 16'hffff), 1'b0);
    send_cmd(slot_write(2, 1'b0, 8'h10, 16'h0000, 16'h00aa), 1'b0);
    send_cmd(slot_write(3, 1'b1, 8'h00, 16'h7fff, 16'h0001), 1'b0);
    send_cmd(table_op(FUNC_READ, 3), 1'b0);
    send_cmd(table_op(FUNC_READ, 4), 1'b0);
    send_cmd(table_op(FUNC_PASS, 0), 1'b0);
    send_cmd(table_op(FUNC_PASS, 0), 1'b0);
    send_cmd(table_op(FUNC_FULL, 0), 1'b0);
    send_cmd(table_op(FUNC_READ, 0), 1'b0);
    send_cmd(table_op(FUNC_READ, 2), 1'b0);
    send_cmd(table_op(FUNC_SPARE_LO, 0), 1'b0);
    send_cmd(table_op(FUNC_SPARE_HI, 0), 1'b0);
    send_cmd(table_op(FUNC_CLEAR, 0), 1'b0);
    send_cmd(table_op(FUNC_READ, 0), 1'b0);
    send_cmd(table_op(FUNC_ALLOC, 0), 1'b0);
    send_cmd(table_op(FUNC_READ, 0), 1'b0);
    send_cmd(table_op(FUNC_PASS, 0), 1'b0);
    settle();

    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 64 : (p == 3) ? 7 : 0;
      send_cmd(table_op(FUNC_CLEAR, 0), 1'b0);
      // phases 1 and 3 run past capacity; phase 3 fills with live entries only
      repeat ((p == 1) ? 68 : (p == 3) ? 66 : (p == 0) ? 12 : 30) begin
        alloc_and_fill((p == 3) ? 100 : 80);
      end
      while (sent_items < 25 + 125 * (p + 1)) random_item((p == 2) ? 60 : 85);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items: %0d alloc, %0d write, %0d read, %0d pass, %0d full sort, %0d clear",
             sent_items, func_hits[FUNC_ALLOC], func_hits[FUNC_WRITE], func_hits[FUNC_READ],
             func_hits[FUNC_PASS], func_hits[FUNC_FULL], func_hits[FUNC_CLEAR]);
    $display("peak used count %0d, %0d allocs refused on a full table, %0d out-of-range accesses",
             peak_used, no_free_seen, range_seen);
    if (fail_count == 0) begin
      $display("draw_order_sort_table verification clean");
    end else begin
      $display("draw_order_sort_table verification failed");
    end
    $finish;
  end

endmodule
